/* src/hrl_pkg.sv */
package hrl_pkg;

    localparam int HRL_PACKET_BYTES = 4096;

    localparam int HDR_NUM = 5;
    localparam int FIELD_NUM = 5;
    localparam int HDR_PAT_CHARS = 11;

    // header pattern slots
    localparam logic [2:0] HDR_HOST    = 3'd0;
    localparam logic [2:0] HDR_AGENT   = 3'd1;
    localparam logic [2:0] HDR_REFERER = 3'd2;
    localparam logic [2:0] HDR_RANGE   = 3'd3;
    localparam logic [2:0] HDR_COOKIE  = 3'd4;

    // captured field slots; FLD_PATH doubles as "no capture pending"
    localparam logic [2:0] FLD_NONE    = 3'd0;
    localparam logic [2:0] FLD_PATH    = 3'd0;
    localparam logic [2:0] FLD_HOST    = 3'd1;
    localparam logic [2:0] FLD_AGENT   = 3'd2;
    localparam logic [2:0] FLD_REFERER = 3'd3;
    localparam logic [2:0] FLD_COOKIE  = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_METHOD = 3'd1;
    localparam logic [2:0] ST_NO_SLASH   = 3'd2;
    localparam logic [2:0] ST_NO_SPACE   = 3'd3;
    localparam logic [2:0] ST_DROP_EXT   = 3'd4;
    localparam logic [2:0] ST_RANGE      = 3'd5;

    localparam logic [7:0] CHR_G     = "G";
    localparam logic [7:0] CHR_E     = "E";
    localparam logic [7:0] CHR_P     = "P";
    localparam logic [7:0] CHR_O     = "O";
    localparam logic [7:0] CHR_SLASH = "/";
    localparam logic [7:0] CHR_SPACE = " ";
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_DOT   = ".";
    localparam logic [7:0] CHR_WILD  = "*";
    localparam logic [7:0] CHR_NUL   = 8'h00;

    // order does not matter, only membership
    localparam logic [8:0][23:0] EXT3 = {"png", "jpg", "gif", "css", "xml",
                                         "mp4", "mp3", "zip", "rar"};
    localparam logic [2:0][31:0] EXT4 = {"webp", "jpeg", "json"};

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_SLASH,
        PH_SPACE,
        PH_SEEK_CR,
        PH_SKIP,
        PH_LINE,
        PH_DONE
    } hrl_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } hrl_byte_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] path_start;
        logic [11:0] path_len;
        logic [11:0] host_start;
        logic [11:0] host_len;
        logic [11:0] agent_start;
        logic [11:0] agent_len;
        logic [11:0] referer_start;
        logic [11:0] referer_len;
        logic [11:0] cookie_start;
        logic [11:0] cookie_len;
    } hrl_result_t;

    // patterns padded on the right to 11 chars; padding lies past hdr_len
    function automatic logic [HDR_PAT_CHARS*8-1:0] hdr_pat(input logic [2:0] c);
        case (c)
            HDR_HOST:    return "Host:******";
            HDR_AGENT:   return "Us*r*A****:";
            HDR_REFERER: return "Re*e*e*:***";
            HDR_RANGE:   return "Ra*ge:*****";
            HDR_COOKIE:  return "Co*k*e:****";
            default:     return {HDR_PAT_CHARS{CHR_WILD}};
        endcase
    endfunction

    function automatic logic [7:0] hdr_char(input logic [2:0] c, input logic [3:0] k);
        logic [HDR_PAT_CHARS*8-1:0] sh;
        sh = hdr_pat(c) << {k, 3'b000};
        if (k >= 4'(HDR_PAT_CHARS)) begin
            return CHR_WILD;
        end
        return sh[HDR_PAT_CHARS*8-1 -: 8];
    endfunction

    function automatic logic [3:0] hdr_len(input logic [2:0] c);
        case (c)
            HDR_HOST:    return 4'd5;
            HDR_AGENT:   return 4'd11;
            HDR_REFERER: return 4'd8;
            HDR_RANGE:   return 4'd6;
            HDR_COOKIE:  return 4'd7;
            default:     return 4'd0;
        endcase
    endfunction

    function automatic logic [3:0] hdr_value_off(input logic [2:0] c);
        case (c)
            HDR_HOST:    return 4'd6;
            HDR_AGENT:   return 4'd12;
            HDR_REFERER: return 4'd9;
            HDR_COOKIE:  return 4'd8;
            default:     return 4'd0;
        endcase
    endfunction

    function automatic logic [2:0] hdr_field(input logic [2:0] c);
        case (c)
            HDR_HOST:    return FLD_HOST;
            HDR_AGENT:   return FLD_AGENT;
            HDR_REFERER: return FLD_REFERER;
            HDR_COOKIE:  return FLD_COOKIE;
            default:     return FLD_NONE;
        endcase
    endfunction

    // a dot four back checks three letters only; otherwise try four letters
    function automatic logic dropped_ext(input logic [7:0] h4, input logic [7:0] h3,
                                         input logic [7:0] h2, input logic [7:0] h1,
                                         input logic [7:0] h0);
        logic hit;
        hit = 1'b0;
        if (h3 == CHR_DOT) begin
            for (int i = 0; i < 9; i++) begin
                if (EXT3[i] == {h2, h1, h0}) begin
                    hit = 1'b1;
                end
            end
        end else if (h4 == CHR_DOT) begin
            for (int i = 0; i < 3; i++) begin
                if (EXT4[i] == {h3, h2, h1, h0}) begin
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

endpackage

/* src/http_request_header_locator.sv */
// Channel   Dir  Width  Contents (lowest bit up)
// s_axis    in   8+1    tdata: data_byte; tlast: last_byte
// m_axis    out  128    tdata: status, path_start, path_len, host_start, host_len,
//                       agent_start, agent_len, referer_start, referer_len,
//                       cookie_start, cookie_len, zero fill
//
// One byte per cycle, unless a last byte is held back. Each byte is held in the input register,
// where the parser state is updated; the result for the packet's last byte is
// loaded into the output register as that byte leaves the input register.
// A last byte waits in the input register while an earlier result is untaken;
// other bytes keep flowing. Reset clears all parser state and both valid flags.
module http_request_header_locator
    import hrl_pkg::*;
#(
    parameter int PACKET_BYTES = HRL_PACKET_BYTES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // status, path_start .. cookie_len, zero fill
);

    logic        item_valid;
    hrl_byte_t   item;
    logic        advance;
    logic        out_busy;
    hrl_result_t result;

    // only the last byte of a request needs the output register free
    assign advance = item_valid && (!item.last || !out_busy || m_axis_tready);

    hrl_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    hrl_parser #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .in_item (item),
        .result  (result)
    );

    hrl_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance && item.last),
        .result        (result),
        .busy          (out_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* src/hrl_in_stage.sv */
module hrl_in_stage
    import hrl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_byte
    input  logic      s_axis_tlast,    // last_byte
    input  logic      advance,
    output logic      item_valid,
    output hrl_byte_t item
);

    logic      valid_reg;
    hrl_byte_t item_reg;

    assign s_axis_tready = !valid_reg || advance;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            item_reg.data <= s_axis_tdata;
            item_reg.last <= s_axis_tlast;
        end
    end

endmodule

/* src/hrl_parser.sv */
module hrl_parser
    import hrl_pkg::*;
#(
    parameter int PACKET_BYTES = HRL_PACKET_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  hrl_byte_t   in_item,
    output hrl_result_t result
);

    // room for the farthest value start: PACKET_BYTES + 1 + 12
    localparam int POS_W = $clog2(PACKET_BYTES + 14);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(PACKET_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    hrl_phase_t       phase_reg, phase_next;
    logic [3:0]       line_off_reg, line_off_next;
    logic [POS_W-1:0] line_start_reg, line_start_next;
    logic [4:0]       cand_reg, cand_next;
    logic [7:0]       hist_reg [5];
    logic [7:0]       hist_next [5];
    logic [2:0]       pend_reg, pend_next;
    logic [POS_W-1:0] start_reg [FIELD_NUM];
    logic [POS_W-1:0] start_next [FIELD_NUM];
    logic [POS_W-1:0] len_reg [FIELD_NUM];
    logic [POS_W-1:0] len_next [FIELD_NUM];
    logic [2:0]       err_reg, err_next;

    function automatic logic [11:0] sat12(input logic [POS_W-1:0] v);
        logic [POS_W+11:0] w;
        w = {12'b0, v};
        return (w > (POS_W+12)'(4095)) ? 12'hFFF : w[11:0];
    endfunction

    always_comb begin
        logic             do_end;
        logic [POS_W-1:0] end_pos;
        logic             fin_en;
        logic [POS_W-1:0] fin_end;
        logic [4:0]       cand_w;
        logic [4:0]       hit;
        logic [7:0]       want;
        logic [7:0]       b;

        pos_next        = pos_reg;
        phase_next      = phase_reg;
        line_off_next   = line_off_reg;
        line_start_next = line_start_reg;
        cand_next       = cand_reg;
        hist_next       = hist_reg;
        pend_next       = pend_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        err_next        = err_reg;

        b       = in_item.data;
        do_end  = 1'b0;
        end_pos = pos_reg;
        fin_en  = 1'b0;
        fin_end = pos_reg;
        cand_w  = cand_reg;
        hit     = '0;
        want    = CHR_WILD;

        if (phase_reg != PH_DONE) begin
            if (pos_reg >= POS_LIMIT) begin
                do_end  = 1'b1;
                end_pos = POS_LIMIT;
            end else if (b == CHR_NUL) begin
                do_end  = 1'b1;
                end_pos = pos_reg;
            end else begin
                case (phase_reg)
                    PH_METHOD: begin
                        if (pos_reg != '0) begin
                            if ((hist_reg[0] == CHR_G && b == CHR_E) ||
                                (hist_reg[0] == CHR_P && b == CHR_O)) begin
                                phase_next = PH_SLASH;
                            end else begin
                                err_next   = ST_BAD_METHOD;
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    PH_SLASH: begin
                        if (b == CHR_SLASH) begin
                            start_next[FLD_PATH] = pos_reg;
                            phase_next           = PH_SPACE;
                        end
                    end
                    PH_SPACE: begin
                        if (b == CHR_SPACE) begin
                            if (dropped_ext(hist_reg[4], hist_reg[3], hist_reg[2],
                                            hist_reg[1], hist_reg[0])) begin
                                err_next   = ST_DROP_EXT;
                                phase_next = PH_DONE;
                            end else begin
                                len_next[FLD_PATH] = pos_reg - start_reg[FLD_PATH];
                                phase_next         = PH_SEEK_CR;
                            end
                        end
                    end
                    PH_SEEK_CR: begin
                        if (b == CHR_CR) begin
                            line_start_next = pos_reg + POS_W'(2);
                            phase_next      = PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        line_off_next = 4'd0;
                        cand_next     = '0;
                        phase_next    = PH_LINE;
                    end
                    PH_LINE: begin
                        if (b == CHR_CR) begin
                            fin_en          = 1'b1;
                            fin_end         = pos_reg;
                            cand_next       = '0;
                            line_start_next = pos_reg + POS_W'(2);
                            phase_next      = PH_SKIP;
                        end else begin
                            if (line_off_reg == 4'd0) begin
                                cand_w = 5'h1F;
                            end
                            for (int c = 0; c < HDR_NUM; c++) begin
                                if (cand_w[c]) begin
                                    want = hdr_char(3'(c), line_off_reg);
                                    if (line_off_reg >= hdr_len(3'(c))) begin
                                        cand_w[c] = 1'b0;
                                    end else if (want != CHR_WILD && b != want) begin
                                        cand_w[c] = 1'b0;
                                    end else if (line_off_reg + 4'd1 == hdr_len(3'(c))) begin
                                        cand_w[c] = 1'b0;
                                        hit[c]    = 1'b1;
                                    end
                                end
                            end
                            if (hit[HDR_RANGE]) begin
                                err_next   = ST_RANGE;
                                phase_next = PH_DONE;
                            end else begin
                                cand_next = cand_w;
                                // pattern lengths differ, so at most one hit per byte
                                for (int c = 0; c < HDR_NUM; c++) begin
                                    if (hit[c]) begin
                                        start_next[hdr_field(3'(c))] = line_start_reg +
                                            POS_W'(hdr_value_off(3'(c)));
                                        len_next[hdr_field(3'(c))] = '0;
                                        pend_next = hdr_field(3'(c));
                                    end
                                end
                                if (line_off_reg != 4'd15) begin
                                    line_off_next = line_off_reg + 4'd1;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                hist_next[0] = b;
                for (int i = 1; i < 5; i++) begin
                    hist_next[i] = hist_reg[i-1];
                end
                pos_next = pos_reg + POS_W'(1);
            end
        end

        // packet ends on this byte with parsing still open
        if (in_item.last && !do_end && phase_next != PH_DONE) begin
            do_end  = 1'b1;
            end_pos = pos_next;
        end

        if (do_end) begin
            case (phase_next)
                PH_METHOD: err_next = ST_BAD_METHOD;
                PH_SLASH:  err_next = ST_NO_SLASH;
                PH_SPACE:  err_next = ST_NO_SPACE;
                PH_LINE: begin
                    fin_en  = 1'b1;
                    fin_end = end_pos;
                end
                default: begin
                end
            endcase
            phase_next = PH_DONE;
        end

        if (fin_en) begin
            for (int f = 1; f < FIELD_NUM; f++) begin
                if (pend_next == 3'(f)) begin
                    len_next[f] = (fin_end > start_next[f]) ? fin_end - start_next[f] : '0;
                end
            end
            pend_next = FLD_NONE;
        end
    end

    always_comb begin
        logic ok;
        ok = (err_next == ST_OK);
        result.status        = err_next;
        result.path_start    = ok ? sat12(start_next[FLD_PATH]) : 12'd0;
        result.path_len      = ok ? sat12(len_next[FLD_PATH]) : 12'd0;
        result.host_start    = ok ? sat12(start_next[FLD_HOST]) : 12'd0;
        result.host_len      = ok ? sat12(len_next[FLD_HOST]) : 12'd0;
        result.agent_start   = ok ? sat12(start_next[FLD_AGENT]) : 12'd0;
        result.agent_len     = ok ? sat12(len_next[FLD_AGENT]) : 12'd0;
        result.referer_start = ok ? sat12(start_next[FLD_REFERER]) : 12'd0;
        result.referer_len   = ok ? sat12(len_next[FLD_REFERER]) : 12'd0;
        result.cookie_start  = ok ? sat12(start_next[FLD_COOKIE]) : 12'd0;
        result.cookie_len    = ok ? sat12(len_next[FLD_COOKIE]) : 12'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && in_item.last)) begin
            pos_reg        <= '0;
            phase_reg      <= PH_METHOD;
            line_off_reg   <= 4'd0;
            line_start_reg <= '0;
            cand_reg       <= '0;
            pend_reg       <= FLD_NONE;
            err_reg        <= ST_OK;
            for (int i = 0; i < 5; i++) begin
                hist_reg[i] <= 8'd0;
            end
            for (int f = 0; f < FIELD_NUM; f++) begin
                start_reg[f] <= '0;
                len_reg[f]   <= '0;
            end
        end else if (step_en) begin
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            line_off_reg   <= line_off_next;
            line_start_reg <= line_start_next;
            cand_reg       <= cand_next;
            pend_reg       <= pend_next;
            err_reg        <= err_next;
            hist_reg       <= hist_next;
            start_reg      <= start_next;
            len_reg        <= len_next;
        end
    end

endmodule

/* src/hrl_out_stage.sv */
module hrl_out_stage
    import hrl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  hrl_result_t  result,
    output logic         busy,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata
);

    logic         valid_reg;
    logic [127:0] data_reg;

    assign busy          = valid_reg;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {5'b0,
                         result.cookie_len, result.cookie_start,
                         result.referer_len, result.referer_start,
                         result.agent_len, result.agent_start,
                         result.host_len, result.host_start,
                         result.path_len, result.path_start,
                         result.status};
        end
    end

endmodule
